### src/drsnoop_pkg.sv
// Package for the DNS response address snooper.
// Parse phases, status codes and result item type; no dependencies.
package drsnoop_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QPTR   = 3'd2,
    PH_QFIXED = 3'd3,
    PH_ANAME  = 3'd4,
    PH_APTR   = 3'd5,
    PH_AFIXED = 3'd6,
    PH_RDATA  = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT_HDR   = 4'd1,
    ST_NOT_RESP    = 4'd2,
    ST_NO_ANSWERS  = 4'd3,
    ST_BAD_QUEST   = 4'd4,
    ST_BAD_ANAME   = 4'd5,
    ST_SHORT_ANS   = 4'd6,
    ST_WRONG_CLASS = 4'd7,
    ST_RD_OVERRUN  = 4'd8
  } status_e;

  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] TYPE_QUAD_A = 16'd28;
  localparam logic [15:0] LEN_A       = 16'd4;
  localparam logic [15:0] LEN_AAAA    = 16'd16;
  localparam logic [14:0] CLASS_INET  = 15'd1;

  typedef struct packed {
    logic        item_kind;
    logic [3:0]  status;
    logic        addr_is_v6;
    logic [31:0] time_to_live;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic [10:0] owner_name_offset;
    logic        final_item;
  } res_t;

  // Results of one byte: up to an address item and a status item
  typedef struct packed {
    logic  addr_vld;
    logic  stat_vld;
    res_t  addr;
    res_t  stat;
  } step_t;

endpackage

### src/drsnoop_parser.sv
// Byte-serial parser state and per-byte decode for the address snooper.
// Depends on drsnoop_pkg; produces at most two result items per byte.
module drsnoop_parser import drsnoop_pkg::*; #(
  parameter int unsigned MaxMessageBytes = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output step_t      step_o
);

  localparam int unsigned PosW = $clog2(MaxMessageBytes + 1);

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       cnt_q, cnt_d, qleft_q, qleft_d, aleft_q, aleft_d;
  logic [10:0]       nstart_q, nstart_d;
  logic [15:0]       rtype_q, rtype_d, rclass_q, rclass_d, rlen_q, rlen_d;
  logic [31:0]       ttl_q, ttl_d;
  logic [63:0]       sh0_q, sh0_d, sh1_q, sh1_d;
  logic              done_q, done_d;

  always_comb begin
    logic        parse, finish, err;
    logic [3:0]  st;
    logic [15:0] cnt_inc, aleft_dec;
    logic [10:0] pos11;
    logic [7:0]  b;
    b         = data_byte_i;
    phase_d   = phase_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    qleft_d   = qleft_q;
    aleft_d   = aleft_q;
    nstart_d  = nstart_q;
    rtype_d   = rtype_q;
    rclass_d  = rclass_q;
    rlen_d    = rlen_q;
    ttl_d     = ttl_q;
    sh0_d     = sh0_q;
    sh1_d     = sh1_q;
    done_d    = done_q;
    finish    = 1'b0;
    err       = 1'b0;
    st        = ST_OK;
    cnt_inc   = cnt_q + 16'd1;
    aleft_dec = aleft_q - 16'd1;
    pos11     = 11'(pos_q);
    step_o    = '0;
    parse     = !done_q && (pos_q < PosW'(MaxMessageBytes));

    if (parse) begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PH_HEADER: begin
          if (pos_q == PosW'(2) || pos_q == PosW'(3)) rclass_d = {rclass_q[7:0], b};
          if (pos_q == PosW'(4) || pos_q == PosW'(5)) qleft_d = {qleft_q[7:0], b};
          if (pos_q == PosW'(6) || pos_q == PosW'(7)) aleft_d = {aleft_q[7:0], b};
          if (pos_q == PosW'(11)) begin
            if (!rclass_q[15]) begin
              err = 1'b1; st = ST_NOT_RESP;
            end else if (aleft_q == '0) begin
              err = 1'b1; st = ST_NO_ANSWERS;
            end else begin
              cnt_d    = '0;
              nstart_d = 11'd12;
              phase_d  = (qleft_q != '0) ? PH_QNAME : PH_ANAME;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 16'd1;
          end else if (b == 8'd0) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
          end else if (b[7:6] == 2'b11) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else if (b[7:6] != 2'b00) begin
            err = 1'b1;
            st  = (phase_q == PH_QNAME) ? ST_BAD_QUEST : ST_BAD_ANAME;
          end else begin
            cnt_d = {8'd0, b};
          end
        end
        PH_QPTR: begin
          phase_d = PH_QFIXED; cnt_d = '0;
        end
        PH_APTR: begin
          phase_d = PH_AFIXED; cnt_d = '0;
        end
        PH_QFIXED: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 16'd4) begin
            cnt_d   = '0;
            qleft_d = qleft_q - 16'd1;
            if (qleft_q == 16'd1) begin
              phase_d  = PH_ANAME;
              nstart_d = pos11 + 11'd1;
            end else begin
              phase_d = PH_QNAME;
            end
          end
        end
        PH_AFIXED: begin
          if (cnt_q < 16'd2)      rtype_d  = {rtype_q[7:0], b};
          else if (cnt_q < 16'd4) rclass_d = {rclass_q[7:0], b};
          else if (cnt_q < 16'd8) ttl_d    = {ttl_q[23:0], b};
          else                    rlen_d   = {rlen_q[7:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= 16'd10) begin
            cnt_d = '0;
            sh0_d = '0;
            sh1_d = '0;
            // class bytes are final here; length low byte is b
            if (rclass_q[14:0] != CLASS_INET) begin
              err = 1'b1; st = ST_WRONG_CLASS;
            end else if ({rlen_q[7:0], b} == 16'd0) begin
              finish = 1'b1;
            end else begin
              phase_d = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          sh0_d = {sh0_q[55:0], sh1_q[63:56]};
          sh1_d = {sh1_q[55:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= rlen_q) finish = 1'b1;
        end
        default: begin
          err = 1'b1; st = ST_SHORT_HDR;
        end
      endcase

      if (finish) begin
        if (rtype_d == TYPE_A && rlen_d == LEN_A) begin
          step_o.addr_vld = 1'b1;
          step_o.addr.time_to_live = ttl_d;
          step_o.addr.addr_lower = {32'd0, sh1_d[31:0]};
          step_o.addr.owner_name_offset = nstart_q;
        end else if (rtype_d == TYPE_QUAD_A && rlen_d == LEN_AAAA) begin
          step_o.addr_vld = 1'b1;
          step_o.addr.addr_is_v6 = 1'b1;
          step_o.addr.time_to_live = ttl_d;
          step_o.addr.addr_upper = sh0_d;
          step_o.addr.addr_lower = sh1_d;
          step_o.addr.owner_name_offset = nstart_q;
        end
        aleft_d = aleft_dec;
        if (aleft_dec == '0) begin
          err = 1'b1; st = ST_OK;
        end else begin
          phase_d  = PH_ANAME;
          cnt_d    = '0;
          nstart_d = pos11 + 11'd1;
        end
      end
      if (err) done_d = 1'b1;
    end

    if (end_of_message_i && !done_d) begin
      err = 1'b1;
      case (phase_d)
        PH_HEADER: st = ST_SHORT_HDR;
        PH_QNAME, PH_QPTR, PH_QFIXED: st = ST_BAD_QUEST;
        PH_RDATA: st = ST_RD_OVERRUN;
        default: st = ST_SHORT_ANS;
      endcase
    end

    if (err) begin
      step_o.stat_vld = 1'b1;
      step_o.stat.item_kind = 1'b1;
      step_o.stat.status = st;
      step_o.stat.final_item = 1'b1;
    end

    if (end_of_message_i) begin
      phase_d = PH_HEADER; pos_d = '0; cnt_d = '0; qleft_d = '0; aleft_d = '0;
      nstart_d = '0; rtype_d = '0; rclass_d = '0; rlen_d = '0; ttl_d = '0;
      sh0_d = '0; sh1_d = '0; done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; cnt_q <= '0; qleft_q <= '0;
      aleft_q <= '0; nstart_q <= '0; rtype_q <= '0; rclass_q <= '0;
      rlen_q <= '0; ttl_q <= '0; sh0_q <= '0; sh1_q <= '0; done_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; pos_q <= pos_d; cnt_q <= cnt_d; qleft_q <= qleft_d;
      aleft_q <= aleft_d; nstart_q <= nstart_d; rtype_q <= rtype_d;
      rclass_q <= rclass_d; rlen_q <= rlen_d; ttl_q <= ttl_d; sh0_q <= sh0_d;
      sh1_q <= sh1_d; done_q <= done_d;
    end
  end

endmodule

### src/drsnoop_outq.sv
// Result queue of four items for the address snooper.
// Depends on drsnoop_pkg; takes up to two items per cycle, gives one.
module drsnoop_outq import drsnoop_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t step_i,
  input  logic  pop_i,
  output logic  valid_o,
  output res_t  head_o,
  output logic  room_o
);

  res_t       mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic [1:0] n_in;
  logic       first_vld;
  res_t       first, second;

  assign first_vld = step_i.addr_vld | step_i.stat_vld;
  assign first     = step_i.addr_vld ? step_i.addr : step_i.stat;
  assign second    = step_i.stat;
  assign n_in      = push_i ? (2'(step_i.addr_vld) + 2'(step_i.stat_vld)) : 2'd0;
  assign valid_o   = cnt_q != '0;
  assign head_o    = mem_q[rd_q];
  // keep room for two more items
  assign room_o    = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_i && first_vld) mem_q[wr_q] <= first;
    if (push_i && step_i.addr_vld && step_i.stat_vld) mem_q[wr_q + 2'd1] <= second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_in;
      rd_q  <= rd_q + 2'(pop_i);
      cnt_q <= cnt_q + 3'(n_in) - 3'(pop_i);
    end
  end

endmodule

### src/dns_response_address_snooper.sv
// Top level of the DNS response address snooper.
// Uses drsnoop_pkg, drsnoop_parser and drsnoop_outq.
//
//  channel | valid          | stall          | payload
//  in      | in_valid_i     | in_stall_o     | data_byte_i, end_of_message_i
//  out     | out_valid_o    | out_stall_i    | item_kind_o .. final_item_o
//
// One byte per cycle while in_stall_o is low; the parser decodes each byte
// combinationally into a four-entry result queue, whose head drives the outputs.
// A byte may yield two items; input stalls while fewer than two slots are free.
// Reset is asynchronous and returns the parser to the header phase.
module dns_response_address_snooper import drsnoop_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [3:0]  status_o,
  output logic        addr_is_v6_o,
  output logic [31:0] time_to_live_o,
  output logic [63:0] addr_upper_o,
  output logic [63:0] addr_lower_o,
  output logic [10:0] owner_name_offset_o,
  output logic        final_item_o
);

  step_t step;
  res_t  head;
  logic  room, take, pop;

  assign in_stall_o = !room;
  assign take       = in_valid_i && room;
  assign pop        = out_valid_o && !out_stall_i;

  drsnoop_parser #(.MaxMessageBytes(MAX_MESSAGE_BYTES)) u_parser (
    .clk_i, .rst_ni, .take_i(take), .data_byte_i, .end_of_message_i, .step_o(step)
  );

  drsnoop_outq u_outq (
    .clk_i, .rst_ni, .push_i(take), .step_i(step), .pop_i(pop),
    .valid_o(out_valid_o), .head_o(head), .room_o(room)
  );

  assign item_kind_o         = head.item_kind;
  assign status_o            = head.status;
  assign addr_is_v6_o        = head.addr_is_v6;
  assign time_to_live_o      = head.time_to_live;
  assign addr_upper_o        = head.addr_upper;
  assign addr_lower_o        = head.addr_lower;
  assign owner_name_offset_o = head.owner_name_offset;
  assign final_item_o        = head.final_item;

  a_addr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !item_kind_o |-> status_o == ST_OK)
    else $error("address item with non-zero status");
  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (item_kind_o == final_item_o))
    else $error("final flag does not match item kind");
  a_v6_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !addr_is_v6_o |-> addr_upper_o == '0)
    else $error("upper address bits set on non-IPv6 item");

endmodule

### sim/tb_dns_response_address_snooper.sv
// Testbench for the DNS response address snooper: random and directed DNS messages.
// Depends on drsnoop_pkg and dns_response_address_snooper; self-checking scoreboard.
module tb_dns_response_address_snooper;
  import drsnoop_pkg::*;

  localparam int MAXB = 512;

  // Predicts the result items of each byte and holds them until they leave the block
  class dns_snoop_board;
    res_t pending[$];
    int errors;
    phase_e ph;
    int unsigned pos_full;
    bit [15:0] cnt, qleft, aleft, rtype, rclass, rlen;
    bit [10:0] nstart;
    bit [31:0] ttl;
    bit [63:0] sh0, sh1;
    bit done;

    function void clear();
      ph = PH_HEADER; pos_full = 0; cnt = 0; qleft = 0; aleft = 0; nstart = 0;
      rtype = 0; rclass = 0; ttl = 0; rlen = 0; sh0 = 0; sh1 = 0; done = 0;
    endfunction

    function void give_status(status_e st);
      res_t r;
      r = '0; r.item_kind = 1'b1; r.status = st; r.final_item = 1'b1;
      pending.push_back(r);
      done = 1;
    endfunction

    function void end_record(int unsigned p);
      res_t r;
      r = '0;
      r.time_to_live = ttl; r.owner_name_offset = nstart;
      if (rtype == TYPE_A && rlen == LEN_A) begin
        r.addr_lower = {32'd0, sh1[31:0]};
        pending.push_back(r);
      end else if (rtype == TYPE_QUAD_A && rlen == LEN_AAAA) begin
        r.addr_is_v6 = 1'b1; r.addr_upper = sh0; r.addr_lower = sh1;
        pending.push_back(r);
      end
      aleft = aleft - 16'd1;
      if (aleft == 0) give_status(ST_OK);
      else begin
        ph = PH_ANAME; cnt = 0; nstart = 11'(p + 1);
      end
    endfunction

    // Returns 0 on a malformed length byte
    function bit walk_name(bit [7:0] b, phase_e pp, phase_e fp);
      if (cnt != 0) cnt = cnt - 16'd1;
      else if (b == 0) begin
        ph = fp; cnt = 0;
      end else if (b[7:6] == 2'b11) ph = pp;
      else if (b[7:6] != 2'b00) return 0;
      else cnt = {8'd0, b};
      return 1;
    endfunction

    function void note_byte(bit [7:0] b, bit eom);
      int unsigned p;
      if (!done && pos_full < MAXB) begin
        p = pos_full; pos_full++;
        case (ph)
          PH_HEADER: begin
            if (p == 2 || p == 3) rclass = {rclass[7:0], b};
            if (p == 4 || p == 5) qleft = {qleft[7:0], b};
            if (p == 6 || p == 7) aleft = {aleft[7:0], b};
            if (p == 11) begin
              if (!rclass[15]) give_status(ST_NOT_RESP);
              else if (aleft == 0) give_status(ST_NO_ANSWERS);
              else begin
                cnt = 0; nstart = 11'd12; ph = (qleft != 0) ? PH_QNAME : PH_ANAME;
              end
            end
          end
          PH_QNAME: if (!walk_name(b, PH_QPTR, PH_QFIXED)) give_status(ST_BAD_QUEST);
          PH_QPTR, PH_APTR: begin
            ph = (ph == PH_QPTR) ? PH_QFIXED : PH_AFIXED; cnt = 0;
          end
          PH_QFIXED: begin
            cnt++;
            if (cnt >= 4) begin
              cnt = 0; qleft = qleft - 16'd1;
              if (qleft == 0) begin
                ph = PH_ANAME; nstart = 11'(p + 1);
              end else ph = PH_QNAME;
            end
          end
          PH_ANAME: if (!walk_name(b, PH_APTR, PH_AFIXED)) give_status(ST_BAD_ANAME);
          PH_AFIXED: begin
            if (cnt < 2) rtype = {rtype[7:0], b};
            else if (cnt < 4) rclass = {rclass[7:0], b};
            else if (cnt < 8) ttl = {ttl[23:0], b};
            else rlen = {rlen[7:0], b};
            cnt++;
            if (cnt >= 10) begin
              cnt = 0; sh0 = 0; sh1 = 0;
              if (rclass[14:0] != CLASS_INET) give_status(ST_WRONG_CLASS);
              else if (rlen == 0) end_record(p);
              else ph = PH_RDATA;
            end
          end
          default: begin
            sh0 = {sh0[55:0], sh1[63:56]};
            sh1 = {sh1[55:0], b};
            cnt++;
            if (cnt >= rlen) end_record(p);
          end
        endcase
      end
      if (eom) begin
        if (!done) begin
          case (ph)
            PH_HEADER: give_status(ST_SHORT_HDR);
            PH_QNAME, PH_QPTR, PH_QFIXED: give_status(ST_BAD_QUEST);
            PH_RDATA: give_status(ST_RD_OVERRUN);
            default: give_status(ST_SHORT_ANS);
          endcase
        end
        clear();
      end
    endfunction

    function void check_item(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item %h", $realtime, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.item_kind != w.item_kind || got.status != w.status ||
          got.addr_is_v6 != w.addr_is_v6 || got.time_to_live != w.time_to_live ||
          got.addr_upper != w.addr_upper || got.addr_lower != w.addr_lower ||
          got.owner_name_offset != w.owner_name_offset ||
          got.final_item != w.final_item) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, w, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, in_stall_o, end_of_message_i, out_valid_o, out_stall_i;
  logic [7:0] data_byte_i;
  logic item_kind_o, addr_is_v6_o, final_item_o;
  logic [3:0] status_o;
  logic [31:0] time_to_live_o;
  logic [63:0] addr_upper_o, addr_lower_o;
  logic [10:0] owner_name_offset_o;

  dns_response_address_snooper #(.MAX_MESSAGE_BYTES(MAXB)) uut (.*);

  dns_snoop_board board;
  bit [7:0] msg[$];
  int items_sent;
  int hold_cycles;
  bit no_idle;
  int quiet;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_byte(bit [7:0] b, bit eom);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1; data_byte_i <= b; end_of_message_i <= eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(b, eom);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic add_name(bit good);
    int nl;
    nl = $urandom_range(0, 2);
    repeat (nl) begin
      int l;
      l = $urandom_range(1, 5);
      msg.push_back(8'(l));
      repeat (l) msg.push_back(8'($urandom));
    end
    if (!good) msg.push_back($urandom_range(0, 1) ? 8'(8'h40 | $urandom_range(0, 63))
                                                 : 8'(8'h80 | $urandom_range(0, 63)));
    else if ($urandom_range(0, 1)) begin
      msg.push_back(8'(8'hC0 | $urandom_range(0, 63))); msg.push_back(8'($urandom));
    end else msg.push_back(8'd0);
  endtask

  // Well-formed response, mostly A and AAAA answers, with rare corruption
  task automatic build_response(int nq, int na);
    msg.delete();
    msg.push_back(8'($urandom)); msg.push_back(8'($urandom));
    msg.push_back(8'(8'h80 | $urandom_range(0, 127))); msg.push_back(8'($urandom));
    msg.push_back(8'd0); msg.push_back(8'(nq));
    msg.push_back(8'd0); msg.push_back(8'(na));
    repeat (4) msg.push_back(8'($urandom));
    repeat (nq) begin
      add_name($urandom_range(0, 30) != 0);
      repeat (4) msg.push_back(8'($urandom));
    end
    repeat (na) begin
      int k, rl;
      k = $urandom_range(0, 9);
      add_name($urandom_range(0, 30) != 0);
      msg.push_back(8'd0);
      msg.push_back(k < 4 ? 8'd1 : k < 8 ? 8'd28 : 8'($urandom));
      msg.push_back({1'($urandom_range(0, 1)), 7'd0});
      msg.push_back($urandom_range(0, 20) == 0 ? 8'($urandom) : 8'd1);
      repeat (4) msg.push_back(8'($urandom));
      rl = k < 4 ? 4 : k < 8 ? 16 : $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) rl = $urandom_range(0, 20);
      msg.push_back(8'd0); msg.push_back(8'(rl));
      repeat (rl) msg.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0 && msg.size() > 1)
      repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 0; out_stall_i = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1; hold_cycles--;
      end else if (no_idle) out_stall_i <= 0;
      else out_stall_i <= ($urandom_range(0, 14) > $urandom_range(0, 14) + 4);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_item('{item_kind_o, status_o, addr_is_v6_o, time_to_live_o,
                         addr_upper_o, addr_lower_o, owner_name_offset_o, final_item_o});
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) quiet = 0;
    else quiet++;
    if (quiet > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    board = new();
    board.clear();
    in_valid_i = 0; data_byte_i = 0; end_of_message_i = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    // Directed: short header, query, no answers, one byte message
    msg = '{8'hFF, 8'h00, 8'h81}; send_msg();
    msg = '{0, 0, 8'h01, 0, 0, 1, 0, 1, 0, 0, 0, 0}; send_msg();
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0}; send_msg();
    msg = '{8'h00}; send_msg();
    // One question and two random answers, sent with no idle gaps or output stalls
    no_idle = 1;
    build_response(1, 2); send_msg();
    no_idle = 0;
    // Long receiver hold while the sender keeps going
    hold_cycles = 300;
    repeat (3) begin
      build_response(0, 3); send_msg();
    end
    drain();
    // Overlong message past the byte limit
    msg.delete();
    msg = '{0, 0, 8'h80, 0, 0, 0, 0, 1, 0, 0, 0, 0, 8'hC0, 8'h0C, 0, 1, 0, 1};
    repeat (MAXB) msg.push_back(8'($urandom));
    no_idle = 1; send_msg(); no_idle = 0;
    drain();
    while (items_sent < 1500) begin
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        msg.delete();
        repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom));
      end else build_response($urandom_range(0, 2), $urandom_range(1, 3));
      if ($urandom_range(0, 20) == 0) no_idle = ~no_idle;
      send_msg();
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
